FILE: hw/rtl/metronome_beat_clock_click_unit_assert.svh
// assertion macros for the metronome click unit
`ifndef METRONOME_BEAT_CLOCK_CLICK_UNIT_ASSERT_SVH
`define METRONOME_BEAT_CLOCK_CLICK_UNIT_ASSERT_SVH

// same-cycle implication
`define MBCC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MBCC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/mbcc_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and codes of the metronome click unit
package mbcc_pkg;

   localparam int unsigned BEATS_PER_BAR_DEF  = 4;
   localparam int unsigned SINE_ROM_DEPTH_DEF = 256;
   localparam int unsigned SAMPLE_WIDTH_DEF   = 16;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] REG_SAMPLES_PER_BEAT    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_METRONOME_ON        = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_CLICK_VOLUME        = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_DOWNBEAT_LENGTH     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_UPBEAT_LENGTH       = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_DOWNBEAT_PHASE_STEP = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_UPBEAT_PHASE_STEP   = 3'd6;

   localparam logic [31:0] SPB_RESET        = 32'd6144000;
   localparam logic [15:0] VOLUME_RESET     = 16'd45875;
   localparam logic [15:0] DOWN_LEN_RESET   = 16'd1440;
   localparam logic [15:0] UP_LEN_RESET     = 16'd960;
   localparam logic [31:0] DOWN_STEP_RESET  = 32'd89478485;
   localparam logic [31:0] UP_STEP_RESET    = 32'd71582788;

   localparam logic [31:0] MIN_PERIOD = 32'd256;
   localparam logic [32:0] POS_STEP   = 33'd256;

   localparam int unsigned OP_W   = 17;
   localparam int unsigned PROD_W = 34;
   localparam int unsigned MAG_W  = 15;
   localparam int unsigned LEN_W  = 16;

   localparam logic [OP_W-1:0] AMP_DOWN   = 17'd26214;
   localparam logic [OP_W-1:0] AMP_UP     = 17'd18350;
   localparam logic [OP_W-1:0] POLY_C0    = 17'd307;
   localparam logic [OP_W-1:0] POLY_C1    = 17'd5223;
   localparam logic [OP_W-1:0] POLY_C2    = 17'd42334;
   localparam logic [OP_W-1:0] POLY_C3    = 17'd102944;
   localparam logic [OP_W-1:0] SINE_SCALE = 17'd32767;
   localparam logic [OP_W-1:0] SINE_MAX   = 17'd32767;
   localparam logic [OP_W-1:0] QUARTER    = 17'd65536;

   localparam int unsigned STEP_W = 4;

   localparam logic [STEP_W-1:0] MUL_T2  = 4'd0;
   localparam logic [STEP_W-1:0] MUL_P1  = 4'd1;
   localparam logic [STEP_W-1:0] MUL_P2  = 4'd2;
   localparam logic [STEP_W-1:0] MUL_P3  = 4'd3;
   localparam logic [STEP_W-1:0] MUL_S   = 4'd4;
   localparam logic [STEP_W-1:0] MUL_V   = 4'd5;
   localparam logic [STEP_W-1:0] MUL_AMP = 4'd6;
   localparam logic [STEP_W-1:0] MUL_VOL = 4'd7;
   localparam logic [STEP_W-1:0] MUL_ENV = 4'd8;

   localparam logic [STEP_W-1:0] DIV_LAST = 4'd14;

   typedef struct packed {
      logic              capture;
      logic              beat;
      logic              mul_en;
      logic [STEP_W-1:0] mul_op;
      logic              div_step;
      logic              out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic click_go;
   } dp_status_type;

endpackage

FILE: hw/rtl/mbcc_ctrl.sv
`timescale 1ns / 1ps
// sequencer of the metronome click unit: handshakes and datapath steps
module mbcc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  mbcc_pkg::dp_status_type dp_status,
   output mbcc_pkg::dp_cmd_type   dp_cmd
);
   import mbcc_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_BEAT = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               dp_cmd.capture = 1'b1;
               state_in       = ST_BEAT;
            end
         end
         ST_BEAT: begin
            dp_cmd.beat = 1'b1;
            step_in     = '0;
            state_in    = dp_status.click_go ? ST_MUL : ST_FIN;
         end
         ST_MUL: begin
            dp_cmd.mul_en = 1'b1;
            dp_cmd.mul_op = step_ff;
            if (step_ff == MUL_ENV) begin
               step_in  = '0;
               state_in = ST_DIV;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DIV: begin
            dp_cmd.div_step = 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = ST_FIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               dp_cmd.out_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (dp_cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hw/rtl/mbcc_datapath.sv
`timescale 1ns / 1ps
// beat clock, click synthesis with shared multiplier and divider, mixer
module mbcc_datapath #(
   parameter int unsigned BEATS_PER_BAR  = mbcc_pkg::BEATS_PER_BAR_DEF,
   parameter int unsigned SINE_ROM_DEPTH = mbcc_pkg::SINE_ROM_DEPTH_DEF,
   parameter int unsigned SAMPLE_WIDTH   = mbcc_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mbcc_pkg::dp_cmd_type              dp_cmd,
   output mbcc_pkg::dp_status_type           dp_status,
   input  logic                              csr_we,
   input  logic [mbcc_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [mbcc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [SAMPLE_WIDTH-1:0]           audio_in,
   input  logic                              reset_beat,
   output logic [SAMPLE_WIDTH-1:0]           audio_out,
   output logic [1:0]                        beat_number,
   output logic                              beat_tick,
   output logic [31:0]                       beat_count,
   output logic [23:0]                       position_in_beat,
   output logic                              click_active
);
   import mbcc_pkg::*;

   localparam int unsigned IDX_W    = $clog2(BEATS_PER_BAR);
   localparam int unsigned ROM_BITS = $clog2(SINE_ROM_DEPTH);
   localparam int unsigned FRAC_W   = ROM_BITS - 2;
   localparam int unsigned PAD_W    = 18 - ROM_BITS;
   localparam int unsigned WIDE_W   = SAMPLE_WIDTH + MAG_W - 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BEATS_PER_BAR - 1);
   localparam logic signed [SAMPLE_WIDTH:0] S_MAX = (SAMPLE_WIDTH+1)'((1 << (SAMPLE_WIDTH-1)) - 1);
   localparam logic signed [SAMPLE_WIDTH:0] S_MIN = ~S_MAX;

   // configuration
   logic [31:0]      spb_ff;
   logic             on_ff;
   logic [15:0]      vol_ff;
   logic [LEN_W-1:0] down_len_ff, up_len_ff;
   logic [31:0]      down_step_ff, up_step_ff;

   // beat and click state
   logic [31:0]      pos_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [31:0]      cnt_ff;
   logic [LEN_W-1:0] rem_ff;
   logic             down_ff;
   logic [31:0]      phase_ff;

   // item work registers
   logic [SAMPLE_WIDTH-1:0] sample_ff;
   logic                    rbeat_ff;
   logic                    tick_ff, active_ff, neg_ff;
   logic [LEN_W-1:0]        total_ff, env_ff;
   logic [OP_W-1:0]         t_ff, t2_ff, poly_ff;
   logic [LEN_W-1:0]        div_rem_ff, div_rem_in;
   logic [MAG_W-1:0]        div_q_ff, div_q_in;

   // output registers
   logic [SAMPLE_WIDTH-1:0] audio_out_ff;
   logic [1:0]              beat_number_ff;
   logic                    beat_tick_ff, click_active_ff;
   logic [31:0]             beat_count_ff;
   logic [23:0]             position_ff;

   // beat update
   logic [31:0]      pos0, period, pos_new, phase_new;
   logic [32:0]      pos_sum, pos_diff;
   logic             crossed, start, go, down_new;
   logic [IDX_W-1:0] idx0, idx_new;
   logic [31:0]      cnt0, cnt_new;
   logic [LEN_W-1:0] rem_new, total_new, env_new;
   logic [15:0]      t16;
   logic [OP_W-1:0]  t_new;

   always_comb begin
      pos0     = rbeat_ff ? '0 : pos_ff;
      idx0     = rbeat_ff ? '0 : idx_ff;
      cnt0     = rbeat_ff ? '0 : cnt_ff;
      period   = (spb_ff < MIN_PERIOD) ? MIN_PERIOD : spb_ff;
      pos_sum  = {1'b0, pos0} + POS_STEP;
      pos_diff = pos_sum - {1'b0, period};
      crossed  = (pos_sum >= {1'b0, period});
      pos_new  = crossed ? pos_diff[31:0] : pos_sum[31:0];
      if (crossed) begin
         idx_new = (idx0 == LAST_IDX) ? '0 : idx0 + 1'b1;
      end else begin
         idx_new = idx0;
      end
      cnt_new   = cnt0 + 32'(crossed);
      start     = crossed && on_ff;
      down_new  = start ? (idx_new == '0) : down_ff;
      total_new = down_new ? down_len_ff : up_len_ff;
      rem_new   = start ? total_new : rem_ff;
      phase_new = start ? '0 : phase_ff;
      go        = on_ff && (rem_new != '0);
      env_new   = (rem_new < total_new) ? rem_new : total_new;
      t16       = {phase_new[29 -: FRAC_W], PAD_W'(0)};
      t_new     = phase_new[30] ? (QUARTER - {1'b0, t16}) : {1'b0, t16};
   end

   assign dp_status.click_go = go;

   // shared multiplier
   logic [OP_W-1:0]   mul_a, mul_b, hi;
   logic [PROD_W-1:0] prod;

   always_comb begin
      unique case (dp_cmd.mul_op)
         MUL_T2:  begin mul_a = t_ff;    mul_b = t_ff;                      end
         MUL_P1:  begin mul_a = t2_ff;   mul_b = POLY_C0;                   end
         MUL_P2:  begin mul_a = t2_ff;   mul_b = poly_ff;                   end
         MUL_P3:  begin mul_a = t2_ff;   mul_b = poly_ff;                   end
         MUL_S:   begin mul_a = t_ff;    mul_b = poly_ff;                   end
         MUL_V:   begin mul_a = poly_ff; mul_b = SINE_SCALE;                end
         MUL_AMP: begin mul_a = poly_ff; mul_b = down_ff ? AMP_DOWN : AMP_UP; end
         MUL_VOL: begin mul_a = poly_ff; mul_b = {1'b0, vol_ff};            end
         MUL_ENV: begin mul_a = poly_ff; mul_b = {1'b0, env_ff};            end
         default: begin mul_a = '0;      mul_b = '0;                        end
      endcase
      prod = PROD_W'(mul_a) * PROD_W'(mul_b);
      hi   = prod[32:16];
   end

   // restoring divide step
   logic [LEN_W:0] shifted, shifted_diff;
   logic           q_bit;

   always_comb begin
      shifted      = {div_rem_ff, div_q_ff[MAG_W-1]};
      shifted_diff = shifted - {1'b0, total_ff};
      q_bit        = (shifted >= {1'b0, total_ff});
      div_rem_in   = q_bit ? shifted_diff[LEN_W-1:0] : shifted[LEN_W-1:0];
      div_q_in     = {div_q_ff[MAG_W-2:0], q_bit};
   end

   // mixer
   logic [MAG_W-1:0]               mag15;
   logic [WIDE_W-1:0]              wide;
   logic [SAMPLE_WIDTH-2:0]        mag;
   logic signed [SAMPLE_WIDTH:0]   click, mix;
   logic [SAMPLE_WIDTH-1:0]        audio_sat;

   always_comb begin
      mag15 = (active_ff && (total_ff != '0)) ? div_q_ff : '0;
      wide  = {mag15, (SAMPLE_WIDTH-1)'(0)};
      mag   = wide[WIDE_W-1:MAG_W];
      click = neg_ff ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
      mix   = $signed({sample_ff[SAMPLE_WIDTH-1], sample_ff}) + click;
      if (mix > S_MAX) begin
         audio_sat = S_MAX[SAMPLE_WIDTH-1:0];
      end else if (mix < S_MIN) begin
         audio_sat = S_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         audio_sat = mix[SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spb_ff       <= SPB_RESET;
         on_ff        <= 1'b0;
         vol_ff       <= VOLUME_RESET;
         down_len_ff  <= DOWN_LEN_RESET;
         up_len_ff    <= UP_LEN_RESET;
         down_step_ff <= DOWN_STEP_RESET;
         up_step_ff   <= UP_STEP_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_SAMPLES_PER_BEAT:    spb_ff       <= csr_wdata;
            REG_METRONOME_ON:        on_ff        <= csr_wdata[0];
            REG_CLICK_VOLUME:        vol_ff       <= csr_wdata[15:0];
            REG_DOWNBEAT_LENGTH:     down_len_ff  <= csr_wdata[LEN_W-1:0];
            REG_UPBEAT_LENGTH:       up_len_ff    <= csr_wdata[LEN_W-1:0];
            REG_DOWNBEAT_PHASE_STEP: down_step_ff <= csr_wdata;
            REG_UPBEAT_PHASE_STEP:   up_step_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         rem_ff   <= '0;
         down_ff  <= 1'b0;
         phase_ff <= '0;
      end else if (dp_cmd.beat) begin
         pos_ff  <= pos_new;
         idx_ff  <= idx_new;
         cnt_ff  <= cnt_new;
         down_ff <= down_new;
         if (go) begin
            rem_ff   <= rem_new - 1'b1;
            phase_ff <= phase_new + (down_new ? down_step_ff : up_step_ff);
         end else begin
            rem_ff   <= rem_new;
            phase_ff <= phase_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         sample_ff <= audio_in;
         rbeat_ff  <= reset_beat;
      end
      if (dp_cmd.beat) begin
         tick_ff   <= crossed;
         active_ff <= go;
         total_ff  <= total_new;
         env_ff    <= env_new;
         t_ff      <= t_new;
         neg_ff    <= phase_new[31];
      end
      if (dp_cmd.mul_en) begin
         unique case (dp_cmd.mul_op)
            MUL_T2:  t2_ff   <= hi;
            MUL_P1:  poly_ff <= POLY_C1 - hi;
            MUL_P2:  poly_ff <= POLY_C2 - hi;
            MUL_P3:  poly_ff <= POLY_C3 - hi;
            MUL_S:   poly_ff <= hi;
            MUL_V:   poly_ff <= (hi > SINE_MAX) ? SINE_MAX : hi;
            MUL_AMP: poly_ff <= hi;
            MUL_VOL: poly_ff <= hi;
            MUL_ENV: begin
               div_rem_ff <= prod[30:15];
               div_q_ff   <= prod[14:0];
            end
            default: ;
         endcase
      end
      if (dp_cmd.div_step) begin
         div_rem_ff <= div_rem_in;
         div_q_ff   <= div_q_in;
      end
      if (dp_cmd.out_load) begin
         audio_out_ff    <= audio_sat;
         beat_number_ff  <= 2'(idx_ff);
         beat_tick_ff    <= tick_ff;
         beat_count_ff   <= cnt_ff;
         position_ff     <= pos_ff[31:8];
         click_active_ff <= active_ff;
      end
   end

   assign audio_out        = audio_out_ff;
   assign beat_number      = beat_number_ff;
   assign beat_tick        = beat_tick_ff;
   assign beat_count       = beat_count_ff;
   assign position_in_beat = position_ff;
   assign click_active     = click_active_ff;

endmodule

FILE: hw/rtl/metronome_beat_clock_click_unit.sv
`timescale 1ns / 1ps
// top level of the metronome beat clock and click generator
//
//   channel  direction  payload
//   req_     in         tdata: audio_in; tuser: reset_beat
//   rsp_     out        tdata: audio_out, beat_number, beat_count, position_in_beat;
//                       tuser: beat_tick, click_active
//   csr_     in         write enable, register index, write data
//
// a beat that sounds a click runs these steps from accept to result, one without skips the multiply and divide:
// accept, beat update, 9 passes through the shared 17x17 multiplier, 15 divider steps, load
// synchronous reset clears configuration to defaults and beat and click state to zero
// the result waits in the output register; the next beat is accepted meanwhile
// and the finished item holds in the last step until that register frees up
`include "metronome_beat_clock_click_unit_assert.svh"

module metronome_beat_clock_click_unit #(
   parameter int unsigned BEATS_PER_BAR  = mbcc_pkg::BEATS_PER_BAR_DEF,
   parameter int unsigned SINE_ROM_DEPTH = mbcc_pkg::SINE_ROM_DEPTH_DEF,
   parameter int unsigned SAMPLE_WIDTH   = mbcc_pkg::SAMPLE_WIDTH_DEF,
   localparam int unsigned REQ_TDATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8,
   localparam int unsigned RSP_TDATA_W   = ((SAMPLE_WIDTH + 58 + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [REQ_TDATA_W-1:0]          req_tdata,  // audio_in
   input  logic                            req_tuser,  // reset_beat
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // audio_out, beat_number, beat_count, position_in_beat
   output logic [RSP_TDATA_W-1:0]          rsp_tdata,
   output logic [1:0]                      rsp_tuser,  // beat_tick, click_active
   input  logic                            csr_we,
   input  logic [mbcc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [mbcc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mbcc_pkg::*;

   dp_cmd_type              dp_cmd;
   dp_status_type           dp_status;
   logic [SAMPLE_WIDTH-1:0] audio_out;
   logic [1:0]              beat_number;
   logic                    beat_tick;
   logic [31:0]             beat_count;
   logic [23:0]             position_in_beat;
   logic                    click_active;

   mbcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   mbcc_datapath #(
      .BEATS_PER_BAR  (BEATS_PER_BAR),
      .SINE_ROM_DEPTH (SINE_ROM_DEPTH),
      .SAMPLE_WIDTH   (SAMPLE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .audio_in         (req_tdata[SAMPLE_WIDTH-1:0]),
      .reset_beat       (req_tuser),
      .audio_out        (audio_out),
      .beat_number      (beat_number),
      .beat_tick        (beat_tick),
      .beat_count       (beat_count),
      .position_in_beat (position_in_beat),
      .click_active     (click_active)
   );

   assign rsp_tdata = RSP_TDATA_W'({position_in_beat, beat_count, beat_number, audio_out});
   assign rsp_tuser = {click_active, beat_tick};

   `MBCC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready && dp_cmd.beat, "accepted beat not followed by beat update")
   `MBCC_ASSERT_SAME(a_no_result_overwrite, clock, reset, dp_cmd.out_load, !rsp_tvalid || rsp_tready, "pending result overwritten")
   `MBCC_ASSERT_NEXT(a_result_after_load, clock, reset, dp_cmd.out_load, rsp_tvalid, "loaded result not offered")

endmodule

FILE: tb/metronome_beat_clock_click_unit_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the metronome beat clock and click unit
module metronome_beat_clock_click_unit_test;
   import mbcc_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_AT     = 140;
   localparam int HOLD_LEN    = 400;

   localparam logic [CSR_ADDR_W-1:0] REG_UNUSED = 3'd7;

   localparam logic [63:0] AMP_DOWNBEAT = 64'd26214;
   localparam logic [63:0] AMP_UPBEAT   = 64'd18350;

   typedef struct packed {
      logic [15:0] audio;
      logic        restart;
   } audio_in_type;

   typedef struct packed {
      logic [15:0] audio;
      logic [1:0]  beat;
      logic        tick;
      logic [31:0] count;
      logic [23:0] position;
      logic        click_on;
   } mix_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata = '0;  // audio_in
   logic                  req_tuser = 1'b0;  // reset_beat
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // audio_out, beat_number, beat_count, position_in_beat
   logic [79:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;  // beat_tick, click_active
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   metronome_beat_clock_click_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow registers and beat/click state
   logic [31:0] spb_q;
   logic        on_q;
   logic [15:0] vol_q;
   logic [15:0] down_len_q;
   logic [15:0] up_len_q;
   logic [31:0] down_step_q;
   logic [31:0] up_step_q;
   logic [31:0] pos_q;
   logic [1:0]  idx_q;
   logic [31:0] count_q;
   logic [15:0] remain_q;
   logic        down_q;
   logic [31:0] phase_q;

   audio_in_type pending[$];
   mix_type      expected[$];
   audio_in_type offered;
   int        mismatches = 0;
   int        results_seen = 0;
   int        cycles = 0;
   int        send_wait = 0;
   int        send_burst = 0;
   int        take_wait = 0;
   int        take_burst = 0;
   int        hold_left = 0;

   // sine polynomial: magnitude 0..32767, sign in neg
   function automatic logic [63:0] sine_mag(input logic [31:0] phase, output logic neg);
      logic [63:0] k, quad, rem, t, t2, p, s, v;
      k = (64'(phase) * 64'd256) >> 32;
      quad = (k * 64'd4) / 64'd256;
      rem = k * 64'd4 - quad * 64'd256;
      t = (rem * 64'd65536) / 64'd256;
      if (quad[0]) t = 64'd65536 - t;
      t2 = (t * t) >> 16;
      p = 64'd5223 - ((t2 * 64'd307) >> 16);
      p = 64'd42334 - ((t2 * p) >> 16);
      p = 64'd102944 - ((t2 * p) >> 16);
      s = (t * p) >> 16;
      v = (s * 64'd32767) >> 16;
      if (v > 64'd32767) v = 64'd32767;
      neg = quad[1];
      return v;
   endfunction

   // advance the beat clock by one sample and mix in the click
   function automatic mix_type mix_next(input logic signed [15:0] audio, input logic restart);
      mix_type     r;
      logic [32:0] pos, period;
      logic [31:0] total, env;
      logic [63:0] mag;
      logic        neg;
      int          mixed;
      period = (spb_q < 32'd256) ? 33'd256 : {1'b0, spb_q};
      if (restart) begin
         pos_q = '0;
         idx_q = '0;
         count_q = '0;
      end
      r.tick = 1'b0;
      r.click_on = 1'b0;
      pos = {1'b0, pos_q} + 33'd256;
      if (pos >= period) begin
         pos = pos - period;
         idx_q = idx_q + 2'd1;
         count_q = count_q + 32'd1;
         r.tick = 1'b1;
         if (on_q) begin
            down_q = (idx_q == 2'd0);
            remain_q = down_q ? down_len_q : up_len_q;
            phase_q = '0;
         end
      end
      pos_q = pos[31:0];
      mixed = int'(audio);
      if (on_q && remain_q != 16'd0) begin
         total = down_q ? down_len_q : up_len_q;
         env = (remain_q < total) ? remain_q : total;
         mag = sine_mag(phase_q, neg);
         mag = (mag * (down_q ? AMP_DOWNBEAT : AMP_UPBEAT)) >> 16;
         mag = (mag * 64'(vol_q)) >> 16;
         mag = (total != 0) ? (mag * 64'(env)) / 64'(total) : 64'd0;
         mixed = neg ? mixed - int'(mag) : mixed + int'(mag);
         phase_q = phase_q + (down_q ? down_step_q : up_step_q);
         remain_q = remain_q - 16'd1;
         r.click_on = 1'b1;
      end
      if (mixed > 32767) mixed = 32767;
      if (mixed < -32768) mixed = -32768;
      r.audio = mixed[15:0];
      r.beat = idx_q;
      r.count = count_q;
      r.position = pos_q[31:8];
      return r;
   endfunction

   // gap length: mostly none, some short, a few long, with idle-free bursts
   function automatic int idle_len(inout int burst);
      int roll;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 3) begin
         burst = $urandom_range(80, 20);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic logic [15:0] pick_audio();
      case ($urandom_range(9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h7FFF - 16'($urandom_range(300));
         3: return 16'h8000 + 16'($urandom_range(300));
         4: return 16'($urandom_range(64));
         default: return 16'($urandom);
      endcase
   endfunction

   // input side: offer queued beats, idle at random
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected.push_back(mix_next(offered.audio, offered.restart));
            send_wait = idle_len(send_burst);
         end
         if (!req_tvalid || req_tready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_tvalid <= 1'b0;
            end else if (pending.size() != 0) begin
               offered = pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= offered.audio;
               req_tuser <= offered.restart;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_result();
      mix_type want, got;
      got.audio = rsp_tdata[15:0];
      got.beat = rsp_tdata[17:16];
      got.count = rsp_tdata[49:18];
      got.position = rsp_tdata[73:50];
      got.tick = rsp_tuser[0];
      got.click_on = rsp_tuser[1];
      if (expected.size() == 0) begin
         $display("%0t unexpected beat: expected none, actual audio_out %0d",
                  $time, got.audio);
         mismatches++;
         return;
      end
      want = expected.pop_front();
      check_field("audio_out", want.audio, got.audio);
      check_field("beat_number", want.beat, got.beat);
      check_field("beat_tick", want.tick, got.tick);
      check_field("beat_count", want.count, got.count);
      check_field("position_in_beat", want.position, got.position);
      check_field("click_active", want.click_on, got.click_on);
   endtask

   // result side: check each beat, stall at random, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result();
            results_seen++;
            if (results_seen == HOLD_AT) hold_left = HOLD_LEN;
            else take_wait = idle_len(take_burst);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (take_wait > 0) begin
            take_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic set_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      #1;
      case (addr)
         REG_SAMPLES_PER_BEAT:    spb_q = value;
         REG_METRONOME_ON:        on_q = value[0];
         REG_CLICK_VOLUME:        vol_q = value[15:0];
         REG_DOWNBEAT_LENGTH:     down_len_q = value[15:0];
         REG_UPBEAT_LENGTH:       up_len_q = value[15:0];
         REG_DOWNBEAT_PHASE_STEP: down_step_q = value;
         REG_UPBEAT_PHASE_STEP:   up_step_q = value;
         default: ;
      endcase
   endtask

   task automatic add_item(input logic [15:0] audio, input logic restart);
      audio_in_type item;
      item.audio = audio;
      item.restart = restart;
      pending.push_back(item);
   endtask

   task automatic add_random(input int n, input int restart_pct);
      for (int i = 0; i < n; i++)
         add_item(pick_audio(), $urandom_range(99) < restart_pct);
   endtask

   task automatic drain();
      do begin
         @(posedge clock);
         #1;
      end while (pending.size() != 0 || req_tvalid || expected.size() != 0);
   endtask

   function automatic logic [31:0] pick_length();
      case ($urandom_range(9))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'd65535;
         default: return $urandom_range(24, 1);
      endcase
   endfunction

   function automatic logic [31:0] pick_step();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic shuffle_config();
      logic [31:0] spb, vol;
      case ($urandom_range(11))
         0: spb = 32'd0;
         1: spb = 32'd255;
         2: spb = 32'd256;
         3: spb = 32'hFFFF_FFFF;
         4: spb = $urandom;
         default: spb = $urandom_range(256 * 12, 257);
      endcase
      case ($urandom_range(5))
         0: vol = 32'd0;
         1: vol = 32'd65535;
         default: vol = $urandom_range(65535);
      endcase
      set_reg(REG_SAMPLES_PER_BEAT, spb);
      set_reg(REG_METRONOME_ON, 32'($urandom_range(3) != 0));
      set_reg(REG_CLICK_VOLUME, vol);
      set_reg(REG_DOWNBEAT_LENGTH, pick_length());
      set_reg(REG_UPBEAT_LENGTH, pick_length());
      set_reg(REG_DOWNBEAT_PHASE_STEP, pick_step());
      set_reg(REG_UPBEAT_PHASE_STEP, pick_step());
      if ($urandom_range(3) == 0) set_reg(REG_UNUSED, $urandom);
   endtask

   initial begin
      spb_q = SPB_RESET;
      on_q = 1'b0;
      vol_q = VOLUME_RESET;
      down_len_q = DOWN_LEN_RESET;
      up_len_q = UP_LEN_RESET;
      down_step_q = DOWN_STEP_RESET;
      up_step_q = UP_STEP_RESET;
      pos_q = '0;
      idx_q = '0;
      count_q = '0;
      remain_q = '0;
      down_q = 1'b0;
      phase_q = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      // defaults, metronome off
      add_item(16'h7FFF, 1'b0);
      add_item(16'h8000, 1'b0);
      drain();

      // period below one sample, full volume
      set_reg(REG_SAMPLES_PER_BEAT, 32'd0);
      set_reg(REG_METRONOME_ON, 32'd1);
      set_reg(REG_CLICK_VOLUME, 32'd65535);
      set_reg(REG_DOWNBEAT_LENGTH, 32'd4);
      set_reg(REG_UPBEAT_LENGTH, 32'd2);
      set_reg(REG_DOWNBEAT_PHASE_STEP, 32'h4000_0000);
      set_reg(REG_UPBEAT_PHASE_STEP, 32'h2000_0000);
      add_item(16'h7FFF, 1'b0);
      add_item(16'h8000, 1'b0);
      add_item(16'h0000, 1'b1);
      add_item(16'hFFFF, 1'b0);
      drain();

      // fractional period, saturation on both rails
      set_reg(REG_SAMPLES_PER_BEAT, 32'd896);
      add_item(16'h7FFF, 1'b0);
      add_item(16'h8000, 1'b0);
      add_item(16'h0000, 1'b0);
      add_item(16'hFFFF, 1'b0);
      add_item(16'h7FFF, 1'b1);
      add_item(16'h8000, 1'b0);
      add_item(16'h0001, 1'b0);
      add_item(16'h7FFE, 1'b0);
      drain();

      // start a long click, then stop the beat clock
      set_reg(REG_SAMPLES_PER_BEAT, 32'd256);
      set_reg(REG_DOWNBEAT_LENGTH, 32'd40);
      set_reg(REG_UPBEAT_LENGTH, 32'd40);
      add_item(16'h1234, 1'b1);
      drain();
      set_reg(REG_SAMPLES_PER_BEAT, 32'hFFFF_FFFF);
      add_item(16'h7FFF, 1'b0);
      add_item(16'h8000, 1'b0);
      drain();
      // click frozen while off, resumes when back on
      set_reg(REG_METRONOME_ON, 32'd0);
      add_item(16'h0100, 1'b0);
      add_item(16'hFF00, 1'b0);
      drain();
      set_reg(REG_METRONOME_ON, 32'd1);
      add_item(16'h0000, 1'b0);
      drain();
      // length cut below remaining count caps the envelope
      set_reg(REG_UPBEAT_LENGTH, 32'd5);
      add_item(16'h0000, 1'b0);
      add_item(16'h4000, 1'b0);
      add_item(16'h0000, 1'b1);
      drain();
      // zero length while sounding gives silent click beats
      set_reg(REG_UPBEAT_LENGTH, 32'd0);
      add_item(16'h0000, 1'b0);
      add_item(16'hC000, 1'b0);
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         shuffle_config();
         add_random(phase == 0 ? 260 : 60, 3);
         drain();
      end

      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
